>>> sv/ffca_pkg.sv
// Package for the first-fit coalescing allocator.
// Holds the request and result types, the codes and the controller states.
// No dependencies.
package ffca_pkg;

  localparam int AddrW    = 32;
  localparam int ReqSizeW = 16;
  localparam int CfgPoolW = 17;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOFIT  = 2'd1,
    ST_REJECT = 2'd2
  } status_e;

  typedef enum logic {
    CFG_POOL_BASE  = 1'b0,
    CFG_POOL_BYTES = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic                cmd;
    logic [ReqSizeW-1:0] req_size;
    logic [AddrW-1:0]    free_addr;
  } req_t;

  typedef struct packed {
    logic [AddrW-1:0] alloc_addr;
    logic [1:0]       status;
  } rsp_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_A_RD,
    S_A_CHK,
    S_A_W2,
    S_A_W3,
    S_F_RD,
    S_F_STEP,
    S_F_W2,
    S_F_R2,
    S_F_C1,
    S_F_C2
  } state_e;

endpackage

>>> sv/ffca_ram.sv
// Simple dual-port synchronous RAM for the allocator header store.
// One write port, one read port, registered read data. Uses ffca_pkg.
module ffca_ram import ffca_pkg::*; #(
  parameter int Width = 17,
  parameter int Depth = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/first_fit_coalescing_allocator_core.sv
// First-fit free-list allocator with coalescing: controller and header stores.
// Depends on ffca_pkg and ffca_ram.
//
//  Channel   | Signals                                   | Handshake
//  ----------+-------------------------------------------+-------------------------
//  request   | start, busy, req_i                        | taken when start & !busy
//  result    | rsp_valid_o, rsp_o                        | one-cycle strobe
//  config    | cfg_valid_i, cfg_ready_o, cfg_index_i,    | written on valid & ready
//            | cfg_wdata_i                               |
//
// A rejected request answers in the cycle after it is taken. An allocate passes S_A_RD
// and S_A_CHK for each free-list entry examined, then S_A_W2 and S_A_W3 when a block
// fits; a free passes S_F_RD and S_F_STEP per entry passed, then S_F_W2, S_F_R2, S_F_C1
// and S_F_C2. Both walks are paced by the single read port of the header stores.
// After reset and after each pool size write, the S_INIT state rebuilds the pool.
// The receiver cannot stall; busy holds off new requests while one is walked.
module first_fit_coalescing_allocator_core import ffca_pkg::*; #(
  parameter int POOL_BYTES    = 65536,
  parameter int GRANULE_BYTES = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  req_t       req_i,
  output logic       rsp_valid_o,
  output rsp_t       rsp_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_index_i,
  input  logic [31:0] cfg_wdata_i
);

  // The granule must be a power of two.
  localparam int NGRAN     = POOL_BYTES / GRANULE_BYTES;
  localparam int LW        = $clog2(NGRAN);
  localparam int KW        = LW + 1;
  localparam int SZW       = $clog2(POOL_BYTES) + 1;
  localparam int GSH       = $clog2(GRANULE_BYTES);
  localparam int HDR_BYTES = ((8 + GRANULE_BYTES - 1) / GRANULE_BYTES) * GRANULE_BYTES;
  localparam int MIN_SPLIT = HDR_BYTES + GRANULE_BYTES;
  localparam int NW        = 18;
  localparam int CW        = (SZW > NW) ? SZW : NW;
  localparam int TW        = CW + 1;
  localparam int OW        = SZW + 1;
  localparam int PW        = (SZW > CfgPoolW) ? SZW : CfgPoolW;
  localparam logic [KW-1:0] LINK_END = KW'(NGRAN);

  state_e state_q, state_d;

  logic [AddrW-1:0]    base_q, base_d;
  logic [CfgPoolW-1:0] pbytes_q, pbytes_d;
  logic [SZW-1:0]      eff_q, eff_d;
  logic [KW-1:0]       head_q, head_d;
  logic [KW-1:0]       cur_q, cur_d;
  logic [KW-1:0]       prev_q, prev_d;
  logic [KW-1:0]       steps_q, steps_d;
  logic [KW-1:0]       nxt_q, nxt_d;
  logic [KW-1:0]       bl_q, bl_d;
  logic [LW-1:0]       b_q, b_d;
  logic [LW-1:0]       tail_q, tail_d;
  logic [NW-1:0]       need_q, need_d;
  logic [SZW-1:0]      sb_q, sb_d;
  logic                split_q, split_d;
  rsp_t                rsp_q, rsp_d;
  logic                rsp_valid_q, rsp_valid_d;

  logic            size_we, link_we;
  logic [LW-1:0]   size_waddr, link_waddr, raddr;
  logic [SZW-1:0]  size_wdata, size_rd;
  logic [KW-1:0]   link_wdata, link_rd;

  ffca_ram #(.Width(SZW), .Depth(NGRAN)) u_size_ram (
    .clk_i   (clk_i),
    .we_i    (size_we),
    .waddr_i (size_waddr),
    .wdata_i (size_wdata),
    .raddr_i (raddr),
    .rdata_o (size_rd)
  );

  ffca_ram #(.Width(KW), .Depth(NGRAN)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .raddr_i (raddr),
    .rdata_o (link_rd)
  );

  // Request decode.
  logic [NW-1:0]    rnd_c, need_c;
  logic [AddrW-1:0] off_c;
  logic             free_ok_c;

  assign rnd_c     = (NW'(req_i.req_size) + NW'(GRANULE_BYTES - 1)) >> GSH;
  assign need_c    = NW'(HDR_BYTES) + (rnd_c << GSH);
  assign off_c     = req_i.free_addr - base_q - AddrW'(HDR_BYTES);
  assign free_ok_c = (off_c[GSH-1:0] == '0) && (off_c < AddrW'(eff_q));

  // Fit test and split.
  logic [CW-1:0]  sz_ext, need_ext;
  logic           fit_c, split_c;
  logic [SZW-1:0] rem_c;
  logic [TW-1:0]  tail_c;

  assign sz_ext   = CW'(size_rd);
  assign need_ext = CW'(need_q);
  assign fit_c    = sz_ext >= need_ext;
  assign rem_c    = SZW'(sz_ext - need_ext);
  assign tail_c   = TW'(cur_q[LW-1:0]) + TW'(need_q >> GSH);
  assign split_c  = (rem_c >= SZW'(MIN_SPLIT)) && (tail_c < TW'(NGRAN));

  // Neighbour adjacency for coalescing.
  logic [OW-1:0]  b_off, b_end, nx_off, p_end;
  logic [SZW-1:0] sum_n, sum_p;
  logic           adj_n, adj_p;

  assign b_off  = OW'(b_q) << GSH;
  assign b_end  = b_off + OW'(sb_q);
  assign nx_off = OW'(cur_q[LW-1:0]) << GSH;
  assign p_end  = (OW'(prev_q[LW-1:0]) << GSH) + OW'(size_rd);
  assign adj_n  = (cur_q < LINK_END) && (b_end == nx_off);
  assign adj_p  = (prev_q < LINK_END) && (p_end == b_off);
  assign sum_n  = sb_q + size_rd;
  assign sum_p  = size_rd + sb_q;

  // Pool restart size.
  logic [PW-1:0] pb_floor, pb_eff;
  assign pb_floor = (PW'(pbytes_q) >> GSH) << GSH;
  assign pb_eff   = (pb_floor > PW'(POOL_BYTES)) ? PW'(POOL_BYTES) : pb_floor;

  always_comb begin
    state_d     = state_q;
    base_d      = base_q;
    pbytes_d    = pbytes_q;
    eff_d       = eff_q;
    head_d      = head_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    steps_d     = steps_q;
    nxt_d       = nxt_q;
    bl_d        = bl_q;
    b_d         = b_q;
    tail_d      = tail_q;
    need_d      = need_q;
    sb_d        = sb_q;
    split_d     = split_q;
    rsp_d       = '0;
    rsp_valid_d = 1'b0;
    size_we     = 1'b0;
    size_waddr  = '0;
    size_wdata  = '0;
    link_we     = 1'b0;
    link_waddr  = '0;
    link_wdata  = '0;
    raddr       = cur_q[LW-1:0];

    case (state_q)
      S_INIT: begin
        eff_d = SZW'(pb_eff);
        if (pb_eff == '0) begin
          head_d = LINK_END;
        end else begin
          size_we    = 1'b1;
          size_wdata = SZW'(pb_eff);
          link_we    = 1'b1;
          link_wdata = LINK_END;
          head_d     = '0;
        end
        state_d = S_IDLE;
      end

      S_IDLE: begin
        if (start) begin
          cur_d   = head_q;
          prev_d  = LINK_END;
          steps_d = '0;
          need_d  = need_c;
          b_d     = off_c[GSH +: LW];
          if (req_i.cmd == CMD_ALLOC) begin
            if (req_i.req_size == '0) begin
              rsp_d.status = ST_REJECT;
              rsp_valid_d  = 1'b1;
            end else begin
              state_d = S_A_RD;
            end
          end else begin
            if (req_i.free_addr == '0 || !free_ok_c) begin
              rsp_d.status = ST_REJECT;
              rsp_valid_d  = 1'b1;
            end else begin
              state_d = S_F_RD;
            end
          end
        end else if (cfg_valid_i) begin
          case (cfg_index_i)
            CFG_POOL_BASE: begin
              base_d = cfg_wdata_i;
            end
            CFG_POOL_BYTES: begin
              pbytes_d = cfg_wdata_i[CfgPoolW-1:0];
              state_d  = S_INIT;
            end
            default: begin
            end
          endcase
        end
      end

      S_A_RD: begin
        if (cur_q >= LINK_END || steps_q >= LINK_END) begin
          rsp_d.status = ST_NOFIT;
          rsp_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end else begin
          state_d = S_A_CHK;
        end
      end

      S_A_CHK: begin
        if (fit_c) begin
          nxt_d   = link_rd;
          split_d = split_c;
          tail_d  = tail_c[LW-1:0];
          if (split_c) begin
            // The remainder becomes a free block that takes over the old link.
            size_we    = 1'b1;
            size_waddr = tail_c[LW-1:0];
            size_wdata = rem_c;
            link_we    = 1'b1;
            link_waddr = tail_c[LW-1:0];
            link_wdata = link_rd;
          end
          state_d = S_A_W2;
        end else begin
          prev_d  = cur_q;
          cur_d   = link_rd;
          steps_d = steps_q + 1'b1;
          state_d = S_A_RD;
        end
      end

      S_A_W2: begin
        if (split_q) begin
          size_we    = 1'b1;
          size_waddr = cur_q[LW-1:0];
          size_wdata = SZW'(need_q);
        end
        if (prev_q >= LINK_END) begin
          head_d = split_q ? KW'(tail_q) : nxt_q;
        end else begin
          link_we    = 1'b1;
          link_waddr = prev_q[LW-1:0];
          link_wdata = split_q ? KW'(tail_q) : nxt_q;
        end
        state_d = S_A_W3;
      end

      S_A_W3: begin
        link_we          = 1'b1;
        link_waddr       = cur_q[LW-1:0];
        link_wdata       = LINK_END;
        rsp_d.alloc_addr = base_q + (AddrW'(cur_q[LW-1:0]) << GSH) + AddrW'(HDR_BYTES);
        rsp_d.status     = ST_OK;
        rsp_valid_d      = 1'b1;
        state_d          = S_IDLE;
      end

      S_F_RD: begin
        if (cur_q < LINK_END && cur_q < KW'(b_q) && steps_q < LINK_END) begin
          state_d = S_F_STEP;
        end else begin
          link_we    = 1'b1;
          link_waddr = b_q;
          link_wdata = cur_q;
          state_d    = S_F_W2;
        end
      end

      S_F_STEP: begin
        prev_d  = cur_q;
        cur_d   = link_rd;
        steps_d = steps_q + 1'b1;
        state_d = S_F_RD;
      end

      S_F_W2: begin
        if (prev_q >= LINK_END) begin
          head_d = KW'(b_q);
        end else begin
          link_we    = 1'b1;
          link_waddr = prev_q[LW-1:0];
          link_wdata = KW'(b_q);
        end
        raddr   = b_q;
        state_d = S_F_R2;
      end

      S_F_R2: begin
        // The block's size arrives; fetch the following free block.
        sb_d    = size_rd;
        state_d = S_F_C1;
      end

      S_F_C1: begin
        if (adj_n) begin
          size_we    = 1'b1;
          size_waddr = b_q;
          size_wdata = sum_n;
          link_we    = 1'b1;
          link_waddr = b_q;
          link_wdata = link_rd;
          sb_d       = sum_n;
          bl_d       = link_rd;
        end else begin
          bl_d = cur_q;
        end
        raddr   = prev_q[LW-1:0];
        state_d = S_F_C2;
      end

      S_F_C2: begin
        if (adj_p) begin
          size_we    = 1'b1;
          size_waddr = prev_q[LW-1:0];
          size_wdata = sum_p;
          link_we    = 1'b1;
          link_waddr = prev_q[LW-1:0];
          link_wdata = bl_q;
        end
        rsp_d.status = ST_OK;
        rsp_valid_d  = 1'b1;
        state_d      = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      base_q      <= '0;
      pbytes_q    <= CfgPoolW'(65536);
      eff_q       <= '0;
      head_q      <= LINK_END;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      base_q      <= base_d;
      pbytes_q    <= pbytes_d;
      eff_q       <= eff_d;
      head_q      <= head_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    prev_q  <= prev_d;
    steps_q <= steps_d;
    nxt_q   <= nxt_d;
    bl_q    <= bl_d;
    b_q     <= b_d;
    tail_q  <= tail_d;
    need_q  <= need_d;
    sb_q    <= sb_d;
    split_q <= split_d;
    rsp_q   <= rsp_d;
  end

  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE) && !start;
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> (rsp_o.status == ST_OK || rsp_o.status == ST_NOFIT ||
                     rsp_o.status == ST_REJECT))
    else $error("result carries an unknown status code");

  a_addr_zero_on_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && rsp_o.status != ST_OK) |-> (rsp_o.alloc_addr == '0))
    else $error("failed request returned a non-zero address");

  a_head_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_INIT) |-> (head_q <= LINK_END))
    else $error("free-list head points beyond the header store");

  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o |-> !busy)
    else $error("configuration accepted while a request is in progress");

endmodule
